// ----- hdl/sidta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: shared package
// Widths, character codes and the status bundle of the BCD converter.
// ----------------------------------------------------------------------------
package sidta_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CNT_W      = 6;
  localparam int LEFT_W     = 4;

  localparam logic [CHAR_W-1:0] DIGIT_BASE = 7'd48;
  localparam logic [CHAR_W-1:0] MINUS_CODE = 7'd45;

  typedef struct packed {
    logic busy;
    logic done;
  } bcd_status_t;

endpackage

// ----- hdl/sidta_bcd.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: serial binary to BCD converter
// Shift-and-add-3 conversion, one magnitude bit per cycle.
// ----------------------------------------------------------------------------
module sidta_bcd (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [sidta_pkg::VALUE_W-1:0]      mag,
  output sidta_pkg::bcd_status_t             status,
  output logic [sidta_pkg::BCD_W-1:0]        bcd
);

  logic [sidta_pkg::VALUE_W-1:0] bin;
  logic [sidta_pkg::CNT_W-1:0]   cnt;
  logic                          busy;
  logic                          done;
  logic [sidta_pkg::BCD_W-1:0]   adj;

  always_comb begin
    for (int i = 0; i < sidta_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= sidta_pkg::CNT_W'(sidta_pkg::VALUE_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == sidta_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[sidta_pkg::VALUE_W-2:0], 1'b0};
      bcd <= {adj[sidta_pkg::BCD_W-2:0], bin[sidta_pkg::VALUE_W-1]};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// ----- hdl/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII
// Converts one signed 32-bit value to its decimal text, one character per
// output request, minus sign first, leading zeros suppressed.
// ----------------------------------------------------------------------------
// The first character follows the serial BCD conversion and a leading-zero scan
// that drops one digit per cycle. Characters then follow one per cycle without stalls.
// A new value is accepted only in the idle state, once the last character of the
// previous value has been registered on the output.
// Reset: synchronous, active high; clears the controller and output valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sidta_pkg::VALUE_W-1:0]   value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sidta_pkg::CHAR_W-1:0]    character,
  output logic                            last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SKIP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                        state;
  logic                              neg;
  logic [sidta_pkg::BCD_W-1:0]       digits;
  logic [sidta_pkg::LEFT_W-1:0]      dleft;
  logic                              start;
  logic [sidta_pkg::VALUE_W-1:0]     mag;
  logic                              slot_free;
  logic [3:0]                        top_digit;
  sidta_pkg::bcd_status_t            bcd_status;
  logic [sidta_pkg::BCD_W-1:0]       bcd;

  assign in_ready  = (state == S_IDLE);
  assign start     = in_valid && in_ready;
  assign mag       = value[sidta_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
  assign slot_free = !out_valid || out_ready;
  assign top_digit = digits[sidta_pkg::BCD_W-1 -: 4];

  sidta_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mag    (mag),
    .status (bcd_status),
    .bcd    (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      neg       <= 1'b0;
      dleft     <= '0;
    end else begin
      if (state == S_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            neg   <= value[sidta_pkg::VALUE_W-1];
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (bcd_status.done) begin
            dleft <= sidta_pkg::LEFT_W'(sidta_pkg::BCD_DIGITS);
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (top_digit == 4'd0 && dleft != sidta_pkg::LEFT_W'(1)) begin
            dleft <= dleft - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (neg) begin
              neg <= 1'b0;
            end else begin
              dleft <= dleft - 1'b1;
              if (dleft == sidta_pkg::LEFT_W'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_CONV: begin
        if (bcd_status.done) begin
          digits <= bcd;
        end
      end
      S_SKIP: begin
        if (top_digit == 4'd0 && dleft != sidta_pkg::LEFT_W'(1)) begin
          digits <= {digits[sidta_pkg::BCD_W-5:0], 4'd0};
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          if (neg) begin
            character <= sidta_pkg::MINUS_CODE;
            last      <= 1'b0;
          end else begin
            character <= sidta_pkg::DIGIT_BASE + {3'b000, top_digit};
            last      <= (dleft == sidta_pkg::LEFT_W'(1));
            digits    <= {digits[sidta_pkg::BCD_W-5:0], 4'd0};
          end
        end
      end
      default: begin
      end
    endcase
  end

  a_start_to_conv: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == S_CONV) && bcd_status.busy)
    else $error("Accepted value did not start a conversion.");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    bcd_status.done |-> (state == S_CONV))
    else $error("Conversion finished outside the conversion state.");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (dleft != '0))
    else $error("Emit state entered with no digits left.");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && character == sidta_pkg::MINUS_CODE) |-> !last)
    else $error("Minus sign marked as the last character.");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && slot_free && !neg && dleft == sidta_pkg::LEFT_W'(1))
      |=> (state == S_IDLE) && out_valid && last)
    else $error("Final digit did not close the request.");

endmodule

// ----- tb/signed_int_to_decimal_ascii_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the signed integer to decimal ASCII converter
// The test sends signed 32-bit values to the converter. It first walks a
// table of directed values: zero, the extremes and some powers of ten. It then
// sends random values spread over every digit count. The characters of each
// expected text wait in a queue, and each output request is compared with the
// oldest one. Both sides pause at random, except during a quiet stretch.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;

  localparam int RANDOM_VALUES = 350;
  localparam int IDLE_PERCENT  = 18;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int QUIET_FROM    = 8000;
  localparam int QUIET_TO      = 12000;
  localparam int DIRECTED_ROWS = 20;

  typedef struct packed {
    logic [sidta_pkg::CHAR_W-1:0] code;
    logic                         last;
  } text_char_t;

  typedef struct {
    logic [sidta_pkg::VALUE_W-1:0] value;
    string                         text;
  } directed_row_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [sidta_pkg::VALUE_W-1:0] value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [sidta_pkg::CHAR_W-1:0]  character;
  logic                          last;

  text_char_t  pending_chars[$];
  int unsigned cycle = 0;
  int unsigned mismatches = 0;
  logic        quiet;

  directed_row_t directed_rows[DIRECTED_ROWS] = '{
    '{32'd0,             "0"},
    '{32'd1,             "1"},
    '{32'hFFFF_FFFF,     "-1"},
    '{32'd9,             ""},
    '{32'd10,            ""},
    '{-32'sd10,          ""},
    '{32'h7FFF_FFFF,     "2147483647"},
    '{32'h8000_0000,     "-2147483648"},
    '{32'h8000_0001,     "-2147483647"},
    '{32'd1000000000,    ""},
    '{-32'sd999999999,   ""},
    '{32'd100,           ""},
    '{32'd1234567890,    ""},
    '{-32'sd123456789,   ""},
    '{32'd99999,         ""},
    '{32'h5555_5555,     ""},
    '{32'hAAAA_AAAA,     ""},
    '{32'h0000_FFFF,     ""},
    '{32'h7FFF_0000,     ""},
    '{32'hFFFF_0000,     ""}
  };

  signed_int_to_decimal_ascii uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  assign quiet = (cycle >= QUIET_FROM) && (cycle < QUIET_TO);

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d characters still expected.",
               cycle, pending_chars.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50)
      $display("Mismatch at cycle %0d: %s", cycle, what);
  endtask

  function automatic void predict_decimal_text(input logic [sidta_pkg::VALUE_W-1:0] v);
    logic [sidta_pkg::VALUE_W-1:0] magnitude;
    logic [3:0]                    digits[sidta_pkg::BCD_DIGITS];
    int                            count;
    magnitude = v[sidta_pkg::VALUE_W-1] ? (~v + 1'b1) : v;
    count = 0;
    do begin
      digits[count] = 4'(magnitude % 10);
      magnitude = magnitude / 10;
      count++;
    end while (magnitude != 0 && count < sidta_pkg::BCD_DIGITS);
    if (v[sidta_pkg::VALUE_W-1])
      pending_chars.push_back('{code: sidta_pkg::MINUS_CODE, last: 1'b0});
    for (int k = count - 1; k >= 0; k--)
      pending_chars.push_back('{code: sidta_pkg::DIGIT_BASE +
                                      sidta_pkg::CHAR_W'(digits[k]),
                                last: k == 0});
  endfunction

  function automatic void queue_typed_text(input string text);
    for (int k = 0; k < text.len(); k++)
      pending_chars.push_back('{code: sidta_pkg::CHAR_W'(text[k]),
                                last: k == text.len() - 1});
  endfunction

  function automatic logic [sidta_pkg::VALUE_W-1:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     digit_count;
    mag = 0;
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        digit_count = $urandom_range(1, 10);
        lo = (digit_count == 1) ? 0 : 10 ** (digit_count - 1);
        hi = (digit_count == 10) ? 64'd2147483648 : 10 ** digit_count - 1;
        mag = $urandom_range(32'(hi), 32'(lo));
      end
      2: begin
        mag = 10 ** $urandom_range(0, 9);
        mag = mag + $urandom_range(2) - 1;
      end
      default: mag = $urandom_range(99);
    endcase
    if ($urandom_range(1))
      mag = -mag;
    return sidta_pkg::VALUE_W'(mag);
  endfunction

  task automatic send_value(input logic [sidta_pkg::VALUE_W-1:0] v, input string text);
    while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    value    = v;
    do @(posedge clk); while (!in_ready);
    if (text.len() > 0)
      queue_typed_text(text);
    else
      predict_decimal_text(v);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst)
      out_ready = 1'b0;
    else
      out_ready = quiet || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d, last %0b", character, last));
      end else begin
        want = pending_chars.pop_front();
        if (character !== want.code)
          report_mismatch($sformatf("character %0d, expected %0d", character, want.code));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b on character %0d, expected %0b",
                                    last, character, want.last));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed_rows[i])
      send_value(directed_rows[i].value, directed_rows[i].text);
    for (int i = 0; i < RANDOM_VALUES; i++)
      send_value(random_value(), "");
    in_valid = 1'b0;
    while (pending_chars.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
